// ----- rtl/core/mdpe_pkg.sv -----
// shared types and constants for the midpoint ellipse rasterizer
`timescale 1ns / 1ps

package mdpe_pkg;

   // field widths
   localparam int AXIS_BITS   = 10;
   localparam int SCREEN_BITS = 11;
   localparam int OUT_BITS    = SCREEN_BITS + 2;
   localparam int COLOR_BITS  = 4;

   // arithmetic widths: squares, slope terms, decision value (scaled by four)
   localparam int SQ_BITS     = 2 * AXIS_BITS;
   localparam int MUL_A_BITS  = 2 * AXIS_BITS + 2;
   localparam int MUL_B_BITS  = 2 * AXIS_BITS;
   localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int OPND_BITS   = PROD_BITS + 2;
   localparam int SLOPE_BITS  = 3 * AXIS_BITS + 2;
   localparam int DEC_BITS    = 4 * AXIS_BITS + 8;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [COLOR_BITS-1:0] COLOR_RESET = 4'd12;

   // register index (word address bit)
   typedef enum logic {
      REG_PIXEL_COLOR = 1'b0
   } reg_index_type;

   // input operation codes
   typedef enum logic {
      OP_START = 1'b0,
      OP_NEXT  = 1'b1
   } op_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQA,
      ST_SQB,
      ST_AB,
      ST_D1,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_E0,
      ST_E1,
      ST_E2,
      ST_E3,
      ST_E4,
      ST_E5,
      ST_DONE
   } state_type;

   // decision accumulator operations
   typedef enum logic [1:0] {
      DOP_HOLD,
      DOP_LOAD,
      DOP_ADD,
      DOP_SUB
   } dec_op_type;

endpackage

// ----- rtl/core/mdpe_mul.sv -----
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps

module mdpe_mul (
   input  logic                              clock,
   input  logic [mdpe_pkg::MUL_A_BITS-1:0]   mul_a,
   input  logic [mdpe_pkg::MUL_B_BITS-1:0]   mul_b,
   output logic [mdpe_pkg::PROD_BITS-1:0]    product
);

   logic [mdpe_pkg::PROD_BITS-1:0] product_ff;
   logic [mdpe_pkg::PROD_BITS-1:0] product_in;

   // one product per cycle
   always_comb begin
      product_in = mdpe_pkg::PROD_BITS'(mul_a) * mdpe_pkg::PROD_BITS'(mul_b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ----- rtl/core/midpoint_ellipse_rasterizer_unit.sv -----
// midpoint ellipse rasterizer: sequencer, decision accumulator, csr and output word
// start word: aa, bb, slope_y, decision; region two set-up too if region one is empty
// next word: midpoint step, region two set-up on entry; no step once the ellipse is done
// no new word until the sequencer is idle again; the multiplier and adder are shared
// a new word is taken while the previous result still waits in the output register
// synchronous reset: empty output, pixel color 12, offsets and center zero (ellipse done)
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_op,
   input  logic [mdpe_pkg::AXIS_BITS-1:0]            req_semi_x,
   input  logic [mdpe_pkg::AXIS_BITS-1:0]            req_semi_y,
   input  logic [mdpe_pkg::SCREEN_BITS-1:0]          req_center_x,
   input  logic [mdpe_pkg::SCREEN_BITS-1:0]          req_center_y,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [mdpe_pkg::OUT_BITS-1:0]      rsp_right_x,
   output logic signed [mdpe_pkg::OUT_BITS-1:0]      rsp_left_x,
   output logic signed [mdpe_pkg::OUT_BITS-1:0]      rsp_upper_y,
   output logic signed [mdpe_pkg::OUT_BITS-1:0]      rsp_lower_y,
   output logic [mdpe_pkg::COLOR_BITS-1:0]           rsp_color,
   output logic                                      rsp_last,
   // configuration port
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [mdpe_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input  logic [mdpe_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   output logic [mdpe_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                      csr_pready
);

   // sequencer state
   mdpe_pkg::state_type state_ff, state_in;

   // ellipse state
   logic [mdpe_pkg::AXIS_BITS-1:0]   semi_x_ff, semi_x_in;
   logic [mdpe_pkg::AXIS_BITS-1:0]   offset_x_ff, offset_x_in;
   logic [mdpe_pkg::AXIS_BITS-1:0]   offset_y_ff, offset_y_in;
   logic [mdpe_pkg::SLOPE_BITS-1:0]  slope_x_ff, slope_x_in;
   logic [mdpe_pkg::SLOPE_BITS-1:0]  slope_y_ff, slope_y_in;
   logic [mdpe_pkg::DEC_BITS-1:0]    decision_ff, decision_in;
   logic [mdpe_pkg::SQ_BITS-1:0]     square_a_ff, square_a_in;
   logic [mdpe_pkg::SQ_BITS-1:0]     square_b_ff, square_b_in;
   logic [mdpe_pkg::SCREEN_BITS-1:0] centre_col_ff, centre_col_in;
   logic [mdpe_pkg::SCREEN_BITS-1:0] centre_row_ff, centre_row_in;
   logic                             region_two_ff, region_two_in;
   logic                             neg_ff, neg_in;

   // configuration
   logic [mdpe_pkg::COLOR_BITS-1:0]  color_ff, color_in;

   // output word
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [mdpe_pkg::OUT_BITS-1:0]  right_x_ff, right_x_in;
   logic signed [mdpe_pkg::OUT_BITS-1:0]  left_x_ff, left_x_in;
   logic signed [mdpe_pkg::OUT_BITS-1:0]  upper_y_ff, upper_y_in;
   logic signed [mdpe_pkg::OUT_BITS-1:0]  lower_y_ff, lower_y_in;
   logic [mdpe_pkg::COLOR_BITS-1:0]       color_out_ff, color_out_in;
   logic                                  last_ff, last_in;

   // shared units
   logic [mdpe_pkg::MUL_A_BITS-1:0]  mul_a;
   logic [mdpe_pkg::MUL_B_BITS-1:0]  mul_b;
   logic [mdpe_pkg::PROD_BITS-1:0]   product;
   mdpe_pkg::dec_op_type             dec_op;
   logic [mdpe_pkg::OPND_BITS-1:0]   dec_opnd;
   logic [mdpe_pkg::DEC_BITS-1:0]    dec_ext;

   // step helpers
   logic                             step_x;
   logic                             step_y;
   logic [mdpe_pkg::AXIS_BITS-1:0]   y_minus_one;
   logic                             csr_write;

   mdpe_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      color_in = color_ff;
      if (csr_write && (csr_paddr[2] == mdpe_pkg::REG_PIXEL_COLOR)) begin
         color_in = csr_pwdata[mdpe_pkg::COLOR_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == mdpe_pkg::REG_PIXEL_COLOR) begin
         csr_prdata = mdpe_pkg::CSR_DATA_BITS'(color_ff);
      end
   end

   // which offsets move on a step
   assign step_x      = region_two_ff ? decision_ff[mdpe_pkg::DEC_BITS-1] : 1'b1;
   assign step_y      = region_two_ff ? 1'b1 : ~decision_ff[mdpe_pkg::DEC_BITS-1];
   assign y_minus_one = (offset_y_ff == '0) ? mdpe_pkg::AXIS_BITS'(1)
                                            : offset_y_ff - mdpe_pkg::AXIS_BITS'(1);

   // sequencer: next state, multiplier operands, accumulator control
   always_comb begin
      state_in      = state_ff;
      semi_x_in     = semi_x_ff;
      offset_x_in   = offset_x_ff;
      offset_y_in   = offset_y_ff;
      slope_x_in    = slope_x_ff;
      slope_y_in    = slope_y_ff;
      square_a_in   = square_a_ff;
      square_b_in   = square_b_ff;
      centre_col_in = centre_col_ff;
      centre_row_in = centre_row_ff;
      region_two_in = region_two_ff;
      neg_in        = neg_ff;
      mul_a         = '0;
      mul_b         = '0;
      dec_op        = mdpe_pkg::DOP_HOLD;
      dec_opnd      = '0;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      right_x_in    = right_x_ff;
      left_x_in     = left_x_ff;
      upper_y_in    = upper_y_ff;
      lower_y_in    = lower_y_ff;
      color_out_in  = color_out_ff;
      last_in       = last_ff;

      case (state_ff)
         mdpe_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op == mdpe_pkg::OP_START) begin
                  semi_x_in     = req_semi_x;
                  offset_x_in   = '0;
                  offset_y_in   = req_semi_y;
                  slope_x_in    = '0;
                  centre_col_in = req_center_x;
                  centre_row_in = req_center_y;
                  region_two_in = 1'b0;
                  state_in      = mdpe_pkg::ST_SQA;
               end else if (offset_y_ff == '0) begin
                  state_in = mdpe_pkg::ST_DONE;
               end else begin
                  state_in = mdpe_pkg::ST_P1;
               end
            end
         end

         // start: aa, bb, then the initial decision and slope_y
         mdpe_pkg::ST_SQA: begin
            mul_a    = mdpe_pkg::MUL_A_BITS'(semi_x_ff);
            mul_b    = mdpe_pkg::MUL_B_BITS'(semi_x_ff);
            state_in = mdpe_pkg::ST_SQB;
         end
         mdpe_pkg::ST_SQB: begin
            mul_a       = mdpe_pkg::MUL_A_BITS'(offset_y_ff);
            mul_b       = mdpe_pkg::MUL_B_BITS'(offset_y_ff);
            square_a_in = product[mdpe_pkg::SQ_BITS-1:0];
            dec_op      = mdpe_pkg::DOP_LOAD;
            dec_opnd    = mdpe_pkg::OPND_BITS'(product);
            state_in    = mdpe_pkg::ST_AB;
         end
         mdpe_pkg::ST_AB: begin
            mul_a       = mdpe_pkg::MUL_A_BITS'(square_a_ff);
            mul_b       = mdpe_pkg::MUL_B_BITS'(offset_y_ff);
            square_b_in = product[mdpe_pkg::SQ_BITS-1:0];
            dec_op      = mdpe_pkg::DOP_ADD;
            dec_opnd    = {product, 2'b00};
            state_in    = mdpe_pkg::ST_D1;
         end
         mdpe_pkg::ST_D1: begin
            slope_y_in = mdpe_pkg::SLOPE_BITS'({product, 1'b0});
            dec_op     = mdpe_pkg::DOP_SUB;
            dec_opnd   = {product, 2'b00};
            // slope_y zero means region one is empty
            state_in   = (product == '0) ? mdpe_pkg::ST_E0 : mdpe_pkg::ST_DONE;
         end

         // one midpoint step: offsets and slopes first
         mdpe_pkg::ST_P1: begin
            neg_in = decision_ff[mdpe_pkg::DEC_BITS-1];
            if (step_x) begin
               offset_x_in = offset_x_ff + mdpe_pkg::AXIS_BITS'(1);
               slope_x_in  = slope_x_ff + mdpe_pkg::SLOPE_BITS'({square_b_ff, 1'b0});
            end
            if (step_y) begin
               offset_y_in = offset_y_ff - mdpe_pkg::AXIS_BITS'(1);
               slope_y_in  = slope_y_ff - mdpe_pkg::SLOPE_BITS'({square_a_ff, 1'b0});
            end
            state_in = mdpe_pkg::ST_P2;
         end
         // then the decision update, one term per cycle
         mdpe_pkg::ST_P2: begin
            dec_op = mdpe_pkg::DOP_ADD;
            if (region_two_ff && !neg_ff) begin
               dec_opnd = mdpe_pkg::OPND_BITS'({square_a_ff, 2'b00});
            end else begin
               dec_opnd = mdpe_pkg::OPND_BITS'({slope_x_ff, 2'b00});
            end
            state_in = mdpe_pkg::ST_P3;
         end
         mdpe_pkg::ST_P3: begin
            if (region_two_ff) begin
               dec_op   = mdpe_pkg::DOP_SUB;
               dec_opnd = mdpe_pkg::OPND_BITS'({slope_y_ff, 2'b00});
            end else begin
               dec_op   = mdpe_pkg::DOP_ADD;
               dec_opnd = mdpe_pkg::OPND_BITS'({square_b_ff, 2'b00});
            end
            state_in = mdpe_pkg::ST_P4;
         end
         mdpe_pkg::ST_P4: begin
            if (region_two_ff) begin
               if (neg_ff) begin
                  dec_op   = mdpe_pkg::DOP_ADD;
                  dec_opnd = mdpe_pkg::OPND_BITS'({square_a_ff, 2'b00});
               end
            end else if (!neg_ff) begin
               dec_op   = mdpe_pkg::DOP_SUB;
               dec_opnd = mdpe_pkg::OPND_BITS'({slope_y_ff, 2'b00});
            end
            // region change once the x slope catches up
            if (!region_two_ff && (offset_y_ff != '0) && (slope_x_ff >= slope_y_ff)) begin
               state_in = mdpe_pkg::ST_E0;
            end else begin
               state_in = mdpe_pkg::ST_DONE;
            end
         end

         // region two start: (2x+1)^2*bb + 4(y-1)^2*aa - 4aa*bb
         mdpe_pkg::ST_E0: begin
            mul_a    = mdpe_pkg::MUL_A_BITS'({offset_x_ff, 1'b1});
            mul_b    = mdpe_pkg::MUL_B_BITS'({offset_x_ff, 1'b1});
            state_in = mdpe_pkg::ST_E1;
         end
         mdpe_pkg::ST_E1: begin
            mul_a    = product[mdpe_pkg::MUL_A_BITS-1:0];
            mul_b    = square_b_ff;
            state_in = mdpe_pkg::ST_E2;
         end
         mdpe_pkg::ST_E2: begin
            dec_op   = mdpe_pkg::DOP_LOAD;
            dec_opnd = mdpe_pkg::OPND_BITS'(product);
            mul_a    = mdpe_pkg::MUL_A_BITS'(y_minus_one);
            mul_b    = mdpe_pkg::MUL_B_BITS'(y_minus_one);
            state_in = mdpe_pkg::ST_E3;
         end
         mdpe_pkg::ST_E3: begin
            mul_a    = product[mdpe_pkg::MUL_A_BITS-1:0];
            mul_b    = square_a_ff;
            state_in = mdpe_pkg::ST_E4;
         end
         mdpe_pkg::ST_E4: begin
            dec_op   = mdpe_pkg::DOP_ADD;
            dec_opnd = {product, 2'b00};
            mul_a    = mdpe_pkg::MUL_A_BITS'(square_a_ff);
            mul_b    = square_b_ff;
            state_in = mdpe_pkg::ST_E5;
         end
         mdpe_pkg::ST_E5: begin
            dec_op        = mdpe_pkg::DOP_SUB;
            dec_opnd      = {product, 2'b00};
            region_two_in = 1'b1;
            state_in      = mdpe_pkg::ST_DONE;
         end

         // hand the mirrored point to the output register once it is free
         mdpe_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               right_x_in   = mdpe_pkg::OUT_BITS'(centre_col_ff)
                            + mdpe_pkg::OUT_BITS'(offset_x_ff);
               left_x_in    = mdpe_pkg::OUT_BITS'(centre_col_ff)
                            - mdpe_pkg::OUT_BITS'(offset_x_ff);
               upper_y_in   = mdpe_pkg::OUT_BITS'(centre_row_ff)
                            - mdpe_pkg::OUT_BITS'(offset_y_ff);
               lower_y_in   = mdpe_pkg::OUT_BITS'(centre_row_ff)
                            + mdpe_pkg::OUT_BITS'(offset_y_ff);
               color_out_in = color_ff;
               last_in      = (offset_y_ff == '0);
               state_in     = mdpe_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mdpe_pkg::ST_IDLE;
         end
      endcase
   end

   // decision accumulator: the one wide adder
   assign dec_ext = mdpe_pkg::DEC_BITS'(dec_opnd);

   always_comb begin
      case (dec_op)
         mdpe_pkg::DOP_LOAD: decision_in = dec_ext;
         mdpe_pkg::DOP_ADD:  decision_in = decision_ff + dec_ext;
         mdpe_pkg::DOP_SUB:  decision_in = decision_ff - dec_ext;
         default:            decision_in = decision_ff;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mdpe_pkg::ST_IDLE;
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
         centre_col_ff <= '0;
         centre_row_ff <= '0;
         region_two_ff <= 1'b0;
         color_ff      <= mdpe_pkg::COLOR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         offset_x_ff   <= offset_x_in;
         offset_y_ff   <= offset_y_in;
         centre_col_ff <= centre_col_in;
         centre_row_ff <= centre_row_in;
         region_two_ff <= region_two_in;
         color_ff      <= color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath and output word registers
   always_ff @(posedge clock) begin
      semi_x_ff    <= semi_x_in;
      slope_x_ff   <= slope_x_in;
      slope_y_ff   <= slope_y_in;
      decision_ff  <= decision_in;
      square_a_ff  <= square_a_in;
      square_b_ff  <= square_b_in;
      neg_ff       <= neg_in;
      right_x_ff   <= right_x_in;
      left_x_ff    <= left_x_in;
      upper_y_ff   <= upper_y_in;
      lower_y_ff   <= lower_y_in;
      color_out_ff <= color_out_in;
      last_ff      <= last_in;
   end

   // ports
   assign req_stall   = (state_ff != mdpe_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_right_x = right_x_ff;
   assign rsp_left_x  = left_x_ff;
   assign rsp_upper_y = upper_y_ff;
   assign rsp_lower_y = lower_y_ff;
   assign rsp_color   = color_out_ff;
   assign rsp_last    = last_ff;

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the midpoint ellipse rasterizer unit
`timescale 1ns / 1ps

module testbench;

   // address of the unused word after the color register, writes there are dropped
   localparam logic [mdpe_pkg::CSR_ADDR_BITS-1:0] CSR_ADDR_SPARE = 3'd4;
   localparam logic [mdpe_pkg::CSR_ADDR_BITS-1:0] CSR_ADDR_COLOR =
      {mdpe_pkg::REG_PIXEL_COLOR, 2'b00};
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef logic [mdpe_pkg::OUT_BITS-1:0] coord_type;

   // one mirrored point quadruple as it leaves the block
   typedef struct {
      coord_type                       right_x;
      coord_type                       left_x;
      coord_type                       upper_y;
      coord_type                       lower_y;
      logic [mdpe_pkg::COLOR_BITS-1:0] color;
      logic                            last;
   } point_word_type;

   // ellipse predictor and store of the points still to come
   class ellipse_scoreboard_type;
      point_word_type                   expected_points[$];
      int                               failures;
      logic [mdpe_pkg::COLOR_BITS-1:0]  color;
      logic [mdpe_pkg::AXIS_BITS-1:0]   off_x, off_y;
      longint                           slope_x, slope_y, dec, sq_a, sq_b;
      logic [mdpe_pkg::SCREEN_BITS-1:0] ctr_col, ctr_row;
      bit                               region_two, done;

      function new();
         failures   = 0;
         color      = mdpe_pkg::COLOR_RESET;
         off_x      = '0;
         off_y      = '0;
         slope_x    = 0;
         slope_y    = 0;
         dec        = 0;
         sq_a       = 0;
         sq_b       = 0;
         ctr_col    = '0;
         ctr_row    = '0;
         region_two = 1'b0;
         done       = 1'b1;
      endfunction

      function void set_color(logic [mdpe_pkg::COLOR_BITS-1:0] value);
         color = value;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      // decision value at the start of region two, scaled by four
      function void start_region_two();
         longint tx, ym;
         tx = 2 * longint'(off_x) + 1;
         ym = longint'(off_y) - 1;
         region_two = 1'b1;
         dec = tx * tx * sq_b + 4 * ym * ym * sq_a - 4 * sq_a * sq_b;
      endfunction

      // one midpoint step
      function void advance_point();
         if (!region_two) begin
            off_x   = off_x + 1'b1;
            slope_x = slope_x + 2 * sq_b;
            if (dec < 0) begin
               dec = dec + 4 * (slope_x + sq_b);
            end else begin
               off_y   = off_y - 1'b1;
               slope_y = slope_y - 2 * sq_a;
               dec     = dec + 4 * (slope_x + sq_b - slope_y);
            end
            if (off_y != 0 && slope_x >= slope_y) start_region_two();
         end else begin
            off_y   = off_y - 1'b1;
            slope_y = slope_y - 2 * sq_a;
            if (dec >= 0) begin
               dec = dec + 4 * (sq_a - slope_y);
            end else begin
               off_x   = off_x + 1'b1;
               slope_x = slope_x + 2 * sq_b;
               dec     = dec + 4 * (slope_x - slope_y + sq_a);
            end
         end
         done = (off_y == 0);
      endfunction

      // accepted request word: update the ellipse and queue its point
      function void note_word(mdpe_pkg::op_type op, logic [mdpe_pkg::AXIS_BITS-1:0] ax,
                              logic [mdpe_pkg::AXIS_BITS-1:0] by,
                              logic [mdpe_pkg::SCREEN_BITS-1:0] col,
                              logic [mdpe_pkg::SCREEN_BITS-1:0] row);
         point_word_type pt;
         longint         a, b;
         if (op == mdpe_pkg::OP_START) begin
            a          = longint'(ax);
            b          = longint'(by);
            ctr_col    = col;
            ctr_row    = row;
            sq_a       = a * a;
            sq_b       = b * b;
            off_x      = '0;
            off_y      = by;
            slope_x    = 0;
            slope_y    = 2 * sq_a * b;
            dec        = 4 * sq_b - 4 * sq_a * b + sq_a;
            region_two = 1'b0;
            if (slope_x >= slope_y) start_region_two();
            done = (b == 0);
         end else if (!done) begin
            advance_point();
         end
         pt.right_x = coord_type'(longint'(ctr_col) + longint'(off_x));
         pt.left_x  = coord_type'(longint'(ctr_col) - longint'(off_x));
         pt.upper_y = coord_type'(longint'(ctr_row) - longint'(off_y));
         pt.lower_y = coord_type'(longint'(ctr_row) + longint'(off_y));
         pt.color   = color;
         pt.last    = (off_y == 0);
         expected_points.push_back(pt);
      endfunction

      function void match_field(string name, coord_type want, coord_type got, bit is_signed);
         if (got !== want) begin
            failures++;
            if (is_signed)
               $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            else
               $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      // accepted response word against the oldest expected point
      function void check_point(point_word_type got);
         point_word_type want;
         if (expected_points.size() == 0) begin
            failures++;
            $error("point word with none expected: right_x %0d lower_y %0d",
                   $signed(got.right_x), $signed(got.lower_y));
            return;
         end
         want = expected_points.pop_front();
         match_field("right_x", want.right_x, got.right_x, 1'b1);
         match_field("left_x", want.left_x, got.left_x, 1'b1);
         match_field("upper_y", want.upper_y, got.upper_y, 1'b1);
         match_field("lower_y", want.lower_y, got.lower_y, 1'b1);
         match_field("color", coord_type'(want.color), coord_type'(got.color), 1'b0);
         match_field("last", coord_type'(want.last), coord_type'(got.last), 1'b0);
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_op = mdpe_pkg::OP_START;
   logic [mdpe_pkg::AXIS_BITS-1:0]       req_semi_x = '0;
   logic [mdpe_pkg::AXIS_BITS-1:0]       req_semi_y = '0;
   logic [mdpe_pkg::SCREEN_BITS-1:0]     req_center_x = '0;
   logic [mdpe_pkg::SCREEN_BITS-1:0]     req_center_y = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [mdpe_pkg::OUT_BITS-1:0] rsp_right_x, rsp_left_x, rsp_upper_y, rsp_lower_y;
   logic [mdpe_pkg::COLOR_BITS-1:0]      rsp_color;
   logic                                 rsp_last;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [mdpe_pkg::CSR_ADDR_BITS-1:0]   csr_paddr = '0;
   logic [mdpe_pkg::CSR_DATA_BITS-1:0]   csr_pwdata = '0;
   logic [mdpe_pkg::CSR_DATA_BITS-1:0]   csr_prdata;
   logic                                 csr_pready;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  pressure_armed = 1'b0;
   bit  pressure_taken = 1'b0;
   int  hold_left = 0;

   ellipse_scoreboard_type board = new();

   midpoint_ellipse_rasterizer_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_semi_x   (req_semi_x),
      .req_semi_y   (req_semi_y),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_right_x  (rsp_right_x),
      .rsp_left_x   (rsp_left_x),
      .rsp_upper_y  (rsp_upper_y),
      .rsp_lower_y  (rsp_lower_y),
      .rsp_color    (rsp_color),
      .rsp_last     (rsp_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response side: check accepted words, random stall and one long hold-off
   always @(posedge clock) begin
      point_word_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.right_x = rsp_right_x;
            got.left_x  = rsp_left_x;
            got.upper_y = rsp_upper_y;
            got.lower_y = rsp_lower_y;
            got.color   = rsp_color;
            got.last    = rsp_last;
            board.check_point(got);
         end
         if (pressure_armed && !pressure_taken) begin
            pressure_taken = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // offer one request word and wait until it is taken
   task automatic send_word(input mdpe_pkg::op_type op,
                            input logic [mdpe_pkg::AXIS_BITS-1:0] ax,
                            input logic [mdpe_pkg::AXIS_BITS-1:0] by,
                            input logic [mdpe_pkg::SCREEN_BITS-1:0] col,
                            input logic [mdpe_pkg::SCREEN_BITS-1:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_semi_x   <= ax;
      req_semi_y   <= by;
      req_center_x <= col;
      req_center_y <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(op, ax, by, col, row);
   endtask

   // start an ellipse and ask for a number of further points
   task automatic run_ellipse(input logic [mdpe_pkg::AXIS_BITS-1:0] ax,
                              input logic [mdpe_pkg::AXIS_BITS-1:0] by,
                              input logic [mdpe_pkg::SCREEN_BITS-1:0] col,
                              input logic [mdpe_pkg::SCREEN_BITS-1:0] row, input int steps);
      send_word(mdpe_pkg::OP_START, ax, by, col, row);
      repeat (steps)
         send_word(mdpe_pkg::OP_NEXT, mdpe_pkg::AXIS_BITS'($urandom_range(1023)),
                   mdpe_pkg::AXIS_BITS'($urandom_range(1023)),
                   mdpe_pkg::SCREEN_BITS'($urandom_range(2047)),
                   mdpe_pkg::SCREEN_BITS'($urandom_range(2047)));
   endtask

   // a setup and an access phase on the csr port, then the bus goes idle
   task automatic csr_access(input bit write, input logic [mdpe_pkg::CSR_ADDR_BITS-1:0] addr,
                             input logic [mdpe_pkg::CSR_DATA_BITS-1:0] wdata,
                             output logic [mdpe_pkg::CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // read the color register back and compare with the predictor
   task automatic verify_color();
      logic [mdpe_pkg::CSR_DATA_BITS-1:0] rd;
      csr_access(1'b0, CSR_ADDR_COLOR, '0, rd);
      if (rd[mdpe_pkg::COLOR_BITS-1:0] !== board.color) begin
         board.failures++;
         $error("pixel_color: expected %0d, got %0d", board.color,
                rd[mdpe_pkg::COLOR_BITS-1:0]);
      end
   endtask

   task automatic write_color(input logic [mdpe_pkg::CSR_DATA_BITS-1:0] value);
      logic [mdpe_pkg::CSR_DATA_BITS-1:0] rd;
      csr_access(1'b1, CSR_ADDR_COLOR, value, rd);
      board.set_color(value[mdpe_pkg::COLOR_BITS-1:0]);
      verify_color();
   endtask

   // stop offering, wait for every expected point, then let the block settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random mix: mostly whole small ellipses, some cut short, some noise words
   task automatic run_random(input int target);
      int sent, pick, lim, a, b, steps;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_word(mdpe_pkg::op_type'($urandom_range(1)),
                      mdpe_pkg::AXIS_BITS'($urandom_range(1023)),
                      mdpe_pkg::AXIS_BITS'($urandom_range(1023)),
                      mdpe_pkg::SCREEN_BITS'($urandom_range(2047)),
                      mdpe_pkg::SCREEN_BITS'($urandom_range(2047)));
            sent++;
         end else begin
            pick = $urandom_range(99);
            lim = (pick < 78) ? 12 : (pick < 93) ? 40 : 1023;
            a = $urandom_range(lim);
            b = $urandom_range(lim);
            if (lim == 1023)
               steps = $urandom_range(30);
            else if ($urandom_range(9) == 0)
               steps = $urandom_range(a + b);
            else
               steps = a + b + $urandom_range(2);
            run_ellipse(mdpe_pkg::AXIS_BITS'(a), mdpe_pkg::AXIS_BITS'(b),
                        mdpe_pkg::SCREEN_BITS'($urandom_range(2047)),
                        mdpe_pkg::SCREEN_BITS'($urandom_range(2047)), steps);
            sent = sent + 1 + steps;
         end
      end
   endtask

   // run ceiling
   initial begin
      #4_000_000;
      $display("midpoint_ellipse_rasterizer_unit verification failed");
      $finish;
   end

   initial begin
      logic [mdpe_pkg::CSR_DATA_BITS-1:0] rd;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_color();

      // directed: next before any start, small ellipse around the origin
      send_word(mdpe_pkg::OP_NEXT, 10'd1023, 10'd1023, 11'd2047, 11'd2047);
      run_ellipse(10'd3, 10'd2, 11'd0, 11'd0, 6);
      // zero vertical axis at the far corner, then next after the end
      run_ellipse(10'd7, 10'd0, 11'd2047, 11'd2047, 1);
      // zero horizontal axis, region one skipped
      run_ellipse(10'd0, 10'd4, 11'd1024, 11'd5, 5);
      // largest axes, cut short by a new start
      run_ellipse(10'd1023, 10'd1023, 11'd2047, 11'd0, 3);
      run_ellipse(10'd1023, 10'd1, 11'd0, 11'd2047, 2);
      run_ellipse(10'd0, 10'd0, 11'd1, 11'd1, 1);
      drain_block();

      // write to the unused address must leave the color alone
      csr_access(1'b1, CSR_ADDR_SPARE, 32'h0000_0005, rd);
      verify_color();

      // phase one: sender idles rarely, receiver often
      write_color(32'd0);
      send_idle_pct = 23;
      recv_idle_pct = 81;
      run_random(440);
      drain_block();

      // phase two: the other way round
      write_color(32'd15);
      send_idle_pct = 81;
      recv_idle_pct = 23;
      run_random(440);
      drain_block();

      // phase three: no idling, one long receiver hold-off
      write_color({$urandom} & ~32'hF | 32'(($urandom_range(13) + 1)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pressure_armed = 1'b1;
      run_random(450);
      drain_block();

      if (board.failures == 0 && board.pending() == 0) begin
         $display("midpoint_ellipse_rasterizer_unit verification clean");
      end else begin
         $display("midpoint_ellipse_rasterizer_unit verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/mdpe_pkg.sv
rtl/core/mdpe_mul.sv
rtl/core/midpoint_ellipse_rasterizer_unit.sv
tb/testbench.sv
